// ===== src/srq_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and saturation helper for the Schroeder reverberator.
// Used by every module of the block except srq_ram; depends on nothing.
package srq_pkg;

	localparam int NUM_COMBS   = 4;
	localparam int NUM_ALLPASS = 2;
	localparam int COMB_LEN    = 2400;
	localparam int ALLPASS_LEN = 480;
	localparam int MIN_DELAY   = 10;

	localparam int S_W    = 16;
	localparam int G_W    = 16;
	localparam int CD_W   = 12;
	localparam int AD_W   = 9;
	localparam int FRAC_W = 15;

	localparam int CD_REG_W = 48;
	localparam int CG_REG_W = 64;
	localparam int AD_REG_W = 18;
	localparam int AG_REG_W = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_COMB_DLY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COMB_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AP_DLY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AP_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WET = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DRY = 3'd5;

	// positions and clamped delays
	localparam int CP_W = $clog2(COMB_LEN + 1);
	localparam int AP_W = $clog2(ALLPASS_LEN + 1);

	localparam int CM_DEPTH  = NUM_COMBS * COMB_LEN;
	localparam int AM_DEPTH  = NUM_ALLPASS * ALLPASS_LEN;
	localparam int CM_AW     = $clog2(CM_DEPTH);
	localparam int AM_AW     = $clog2(AM_DEPTH);
	localparam int CLR_DEPTH = (CM_DEPTH > AM_DEPTH) ? CM_DEPTH : AM_DEPTH;
	localparam int CLR_W     = $clog2(CLR_DEPTH);

	localparam int CI_W  = $clog2(NUM_COMBS + 1);
	localparam int CIX_W = (NUM_COMBS > 1) ? $clog2(NUM_COMBS) : 1;
	localparam int AIX_W = (NUM_ALLPASS > 1) ? $clog2(NUM_ALLPASS) : 1;

	localparam int ACC_W    = S_W + CI_W;
	localparam int MB_W     = S_W + 2;
	localparam int P_W      = G_W + MB_W;
	localparam int PS_W     = P_W - FRAC_W;
	localparam int SAT_IN_W = 24;

	localparam logic signed [SAT_IN_W-1:0] SAT_HI = 24'sd32767;
	localparam logic signed [SAT_IN_W-1:0] SAT_LO = -24'sd32768;

	typedef struct packed {
		logic [NUM_COMBS-1:0][CP_W-1:0]   comb_dly;
		logic [NUM_COMBS-1:0][G_W-1:0]    comb_gain;
		logic [NUM_ALLPASS-1:0][AP_W-1:0] ap_dly;
		logic [NUM_ALLPASS-1:0][G_W-1:0]  ap_gain;
		logic signed [G_W-1:0]            wet;
		logic signed [G_W-1:0]            dry;
	} srq_cfg_t;

	typedef struct packed {
		logic ready;
		logic res_valid;
	} srq_stat_t;

	function automatic logic signed [S_W-1:0] sat16(input logic signed [SAT_IN_W-1:0] v);
		if (v > SAT_HI)
			return S_W'(SAT_HI);
		else if (v < SAT_LO)
			return S_W'(SAT_LO);
		else
			return S_W'(v);
	endfunction

endpackage

// ===== src/srq_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stands alone; no package needed.
module srq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/srq_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file: decodes writes, unpacks and clamps per-section fields.
// Depends on srq_pkg.
module srq_cfg import srq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] data,
	output srq_cfg_t              cfg
);

	logic [CD_REG_W-1:0]   cd_q;
	logic [CG_REG_W-1:0]   cg_q;
	logic [AD_REG_W-1:0]   ad_q;
	logic [AG_REG_W-1:0]   ag_q;
	logic signed [G_W-1:0] wet_q;
	logic signed [G_W-1:0] dry_q;

	function automatic logic [CP_W-1:0] clamp_comb(input logic [CD_W-1:0] f);
		if (f < CD_W'(MIN_DELAY))
			return CP_W'(MIN_DELAY);
		else if (f > CD_W'(COMB_LEN))
			return CP_W'(COMB_LEN);
		else
			return CP_W'(f);
	endfunction

	function automatic logic [AP_W-1:0] clamp_ap(input logic [AD_W-1:0] f);
		if (f < AD_W'(MIN_DELAY))
			return AP_W'(MIN_DELAY);
		else if (f > AD_W'(ALLPASS_LEN))
			return AP_W'(ALLPASS_LEN);
		else
			return AP_W'(f);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_q  <= '0;
			cg_q  <= '0;
			ad_q  <= '0;
			ag_q  <= '0;
			wet_q <= '0;
			dry_q <= 16'sd32767;
		end else if (we) begin
			case (index)
				REG_COMB_DLY:  cd_q  <= data[CD_REG_W-1:0];
				REG_COMB_GAIN: cg_q  <= data[CG_REG_W-1:0];
				REG_AP_DLY:    ad_q  <= data[AD_REG_W-1:0];
				REG_AP_GAIN:   ag_q  <= data[AG_REG_W-1:0];
				REG_WET:       wet_q <= data[G_W-1:0];
				REG_DRY:       dry_q <= data[G_W-1:0];
				default: ;
			endcase
		end
	end

	// sections whose field lies beyond the register read a zero gain and the minimum delay
	for (genvar i = 0; i < NUM_COMBS; i++) begin : g_comb
		if (i * CD_W < CD_REG_W) begin : g_dly
			assign cfg.comb_dly[i] = clamp_comb(cd_q[i*CD_W +: CD_W]);
		end else begin : g_dly_none
			assign cfg.comb_dly[i] = CP_W'(MIN_DELAY);
		end
		if (i * G_W < CG_REG_W) begin : g_gain
			assign cfg.comb_gain[i] = cg_q[i*G_W +: G_W];
		end else begin : g_gain_none
			assign cfg.comb_gain[i] = '0;
		end
	end

	for (genvar i = 0; i < NUM_ALLPASS; i++) begin : g_ap
		if (i * AD_W < AD_REG_W) begin : g_dly
			assign cfg.ap_dly[i] = clamp_ap(ad_q[i*AD_W +: AD_W]);
		end else begin : g_dly_none
			assign cfg.ap_dly[i] = AP_W'(MIN_DELAY);
		end
		if (i * G_W < AG_REG_W) begin : g_gain
			assign cfg.ap_gain[i] = ag_q[i*G_W +: G_W];
		end else begin : g_gain_none
			assign cfg.ap_gain[i] = '0;
		end
	end

	assign cfg.wet = wet_q;
	assign cfg.dry = dry_q;

endmodule

// ===== src/srq_core.sv =====
`timescale 1ns / 1ps
// Reverb sequencer: comb and all-pass delay memories, one shared multiplier,
// read-modify-write of each line. Depends on srq_pkg and srq_ram.
module srq_core import srq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  srq_cfg_t              cfg,
	input  logic                  start,
	input  logic signed [S_W-1:0] sample,
	input  logic                  res_take,
	output srq_stat_t             stat,
	output logic signed [S_W-1:0] result
);

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_COMB   = 4'd2;
	localparam logic [3:0] ST_SUM    = 4'd3;
	localparam logic [3:0] ST_AP_RD  = 4'd4;
	localparam logic [3:0] ST_AP_M1  = 4'd5;
	localparam logic [3:0] ST_AP_V   = 4'd6;
	localparam logic [3:0] ST_AP_M2  = 4'd7;
	localparam logic [3:0] ST_AP_WR  = 4'd8;
	localparam logic [3:0] ST_MIX_D  = 4'd9;
	localparam logic [3:0] ST_MIX_W  = 4'd10;
	localparam logic [3:0] ST_MIX_O  = 4'd11;
	localparam logic [3:0] ST_DONE   = 4'd12;

	logic [3:0]              state_q;
	logic [CLR_W-1:0]        clr_q;
	logic signed [S_W-1:0]   x_q;
	logic [NUM_COMBS-1:0][CP_W-1:0]   comb_pos_q;
	logic [NUM_ALLPASS-1:0][AP_W-1:0] ap_pos_q;

	logic [CI_W-1:0]         crd_q;
	logic [CM_AW-1:0]        cbase_q;
	logic                    v_s1;
	logic [CIX_W-1:0]        cidx_s1;
	logic [CM_AW-1:0]        caddr_s1;
	logic                    v_s2;
	logic [CM_AW-1:0]        caddr_s2;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [S_W-1:0]   sig_q;
	logic signed [P_W-1:0]   prod_q;
	logic signed [S_W-1:0]   d_q;
	logic signed [MB_W-1:0]  v_q;
	logic signed [PS_W-1:0]  mix_q;
	logic [AIX_W-1:0]        aidx_q;
	logic [AM_AW-1:0]        abase_q;
	logic [AM_AW-1:0]        aaddr_q;
	logic signed [S_W-1:0]   res_q;

	// memory ports
	logic             c_we;
	logic [CM_AW-1:0] c_waddr;
	logic [S_W-1:0]   c_wdata;
	logic [CM_AW-1:0] c_raddr;
	logic [S_W-1:0]   c_rdata;
	logic             a_we;
	logic [AM_AW-1:0] a_waddr;
	logic [S_W-1:0]   a_wdata;
	logic [AM_AW-1:0] a_raddr;
	logic [S_W-1:0]   a_rdata;

	// comb addressing
	logic [CIX_W-1:0] cix;
	logic             c_issue;
	logic [CP_W-1:0]  cp_eff;
	logic [CP_W:0]    cp_inc;
	logic [CP_W-1:0]  cp_next;

	// all-pass addressing
	logic [AP_W-1:0]  ap_eff;
	logic [AP_W:0]    ap_inc;
	logic [AP_W-1:0]  ap_next;

	// arithmetic
	logic signed [G_W-1:0]      mul_a;
	logic signed [MB_W-1:0]     mul_b;
	logic signed [P_W-1:0]      prod;
	logic signed [PS_W-1:0]     prod_sh;
	logic signed [S_W-1:0]      att;
	logic signed [SAT_IN_W-1:0] comb_sum;
	logic signed [SAT_IN_W-1:0] sig_sum;
	logic signed [SAT_IN_W-1:0] v_sum;
	logic signed [SAT_IN_W-1:0] y_sum;
	logic signed [SAT_IN_W-1:0] mix_sum;
	logic signed [MB_W-1:0]     c_rdata_x;
	logic signed [MB_W-1:0]     a_rdata_x;

	srq_ram #(.WIDTH(S_W), .DEPTH(CM_DEPTH)) u_comb_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	srq_ram #(.WIDTH(S_W), .DEPTH(AM_DEPTH)) u_ap_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	assign c_rdata_x = MB_W'($signed(c_rdata));
	assign a_rdata_x = MB_W'($signed(a_rdata));
	assign att       = x_q >>> 2;

	// comb read side: the position as it stands, then advance and wrap on the delay
	assign cix     = crd_q[CIX_W-1:0];
	assign c_issue = (state_q == ST_COMB) && (crd_q != CI_W'(NUM_COMBS));
	assign cp_eff  = (comb_pos_q[cix] >= CP_W'(COMB_LEN)) ? '0 : comb_pos_q[cix];
	assign cp_inc  = {1'b0, cp_eff} + 1'b1;
	assign cp_next = (cp_inc >= {1'b0, cfg.comb_dly[cix]}) ? '0 : cp_inc[CP_W-1:0];
	assign c_raddr = cbase_q + CM_AW'(cp_eff);

	assign ap_eff  = (ap_pos_q[aidx_q] >= AP_W'(ALLPASS_LEN)) ? '0 : ap_pos_q[aidx_q];
	assign ap_inc  = {1'b0, ap_eff} + 1'b1;
	assign ap_next = (ap_inc >= {1'b0, cfg.ap_dly[aidx_q]}) ? '0 : ap_inc[AP_W-1:0];
	assign a_raddr = abase_q + AM_AW'(ap_eff);

	// shared multiplier, operands chosen by phase
	always_comb begin
		mul_a = cfg.dry;
		mul_b = '0;
		case (state_q)
			ST_COMB: begin
				mul_a = $signed(cfg.comb_gain[cidx_s1]);
				mul_b = c_rdata_x;
			end
			ST_AP_M1: begin
				mul_a = $signed(cfg.ap_gain[aidx_q]);
				mul_b = a_rdata_x;
			end
			ST_AP_M2: begin
				mul_a = $signed(cfg.ap_gain[aidx_q]);
				mul_b = v_q;
			end
			ST_MIX_D: begin
				mul_a = cfg.dry;
				mul_b = MB_W'(x_q);
			end
			ST_MIX_W: begin
				mul_a = cfg.wet;
				mul_b = MB_W'(sig_q);
			end
			default: ;
		endcase
	end

	assign prod    = P_W'(mul_a) * P_W'(mul_b);
	assign prod_sh = $signed(prod_q[P_W-1:FRAC_W]);

	assign comb_sum = SAT_IN_W'(att) + SAT_IN_W'(prod_sh);
	assign sig_sum  = SAT_IN_W'(acc_q >>> 1);
	assign v_sum    = SAT_IN_W'(sig_q) + SAT_IN_W'(prod_sh);
	assign y_sum    = SAT_IN_W'(d_q) - SAT_IN_W'(prod_sh);
	assign mix_sum  = SAT_IN_W'(mix_q) + SAT_IN_W'(prod_sh);

	// write ports: zero sweep after reset, otherwise the line updates
	always_comb begin
		if (state_q == ST_CLEAR) begin
			c_we    = (clr_q < CLR_W'(CM_DEPTH));
			c_waddr = CM_AW'(clr_q);
			c_wdata = '0;
			a_we    = (clr_q < CLR_W'(AM_DEPTH));
			a_waddr = AM_AW'(clr_q);
			a_wdata = '0;
		end else begin
			c_we    = v_s2;
			c_waddr = caddr_s2;
			c_wdata = sat16(comb_sum);
			a_we    = (state_q == ST_AP_WR);
			a_waddr = aaddr_q;
			a_wdata = sat16(SAT_IN_W'(v_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			comb_pos_q <= '0;
			ap_pos_q   <= '0;
			crd_q      <= '0;
			aidx_q     <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
		end else begin
			v_s1 <= c_issue;
			v_s2 <= v_s1;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CLR_DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						crd_q   <= '0;
						state_q <= ST_COMB;
					end
				end
				ST_COMB: begin
					if (c_issue) begin
						comb_pos_q[cix] <= cp_next;
						crd_q           <= crd_q + 1'b1;
					end
					// last write of the sweep goes out this cycle
					if (!c_issue && !v_s1 && v_s2)
						state_q <= ST_SUM;
				end
				ST_SUM: begin
					aidx_q  <= '0;
					state_q <= ST_AP_RD;
				end
				ST_AP_RD: begin
					ap_pos_q[aidx_q] <= ap_next;
					state_q          <= ST_AP_M1;
				end
				ST_AP_M1: state_q <= ST_AP_V;
				ST_AP_V:  state_q <= ST_AP_M2;
				ST_AP_M2: state_q <= ST_AP_WR;
				ST_AP_WR: begin
					if (aidx_q == AIX_W'(NUM_ALLPASS - 1)) begin
						state_q <= ST_MIX_D;
					end else begin
						aidx_q  <= aidx_q + 1'b1;
						state_q <= ST_AP_RD;
					end
				end
				ST_MIX_D: state_q <= ST_MIX_W;
				ST_MIX_W: state_q <= ST_MIX_O;
				ST_MIX_O: state_q <= ST_DONE;
				ST_DONE: begin
					if (res_take)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q   <= prod;
		cidx_s1  <= cix;
		caddr_s1 <= c_raddr;
		caddr_s2 <= caddr_s1;
		if (state_q == ST_IDLE && start) begin
			x_q     <= sample;
			acc_q   <= '0;
			cbase_q <= '0;
		end
		if (c_issue)
			cbase_q <= cbase_q + CM_AW'(COMB_LEN);
		if (v_s1)
			acc_q <= acc_q + ACC_W'($signed(c_rdata));
		case (state_q)
			ST_SUM: begin
				sig_q   <= sat16(sig_sum);
				abase_q <= '0;
			end
			ST_AP_RD: aaddr_q <= a_raddr;
			ST_AP_M1: d_q <= $signed(a_rdata);
			ST_AP_V:  v_q <= MB_W'(v_sum);
			ST_AP_WR: begin
				sig_q   <= sat16(y_sum);
				abase_q <= abase_q + AM_AW'(ALLPASS_LEN);
			end
			ST_MIX_W: mix_q <= prod_sh;
			ST_MIX_O: res_q <= sat16(mix_sum);
			default: ;
		endcase
	end

	assign stat.ready     = (state_q == ST_IDLE);
	assign stat.res_valid = (state_q == ST_DONE);
	assign result         = res_q;

endmodule

// ===== src/schroeder_reverb_q15.sv =====
`timescale 1ns / 1ps
// Schroeder reverberator, Q15 fixed point, one sample word in, one word out.
// A sample is accepted only while the core is idle; out_valid rises once the comb sweep,
// the serial all-pass chain and the mix have run on the single shared multiplier, and no
// new word is taken until the result has been loaded into the output register.
// Reset: a zeroing sweep runs over all CLR_DEPTH addresses (9600) of the delay memories;
// in_stall stays high meanwhile, configuration writes are taken throughout.
module schroeder_reverb_q15 import srq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [S_W-1:0] sample_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [S_W-1:0] sample_out,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	srq_cfg_t              cfg;
	srq_stat_t             stat;
	logic signed [S_W-1:0] result;
	logic                  start;
	logic                  res_take;
	logic                  out_valid_q;
	logic signed [S_W-1:0] sample_out_q;

	assign cfg_ready = 1'b1;

	srq_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_valid && cfg_ready),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	assign in_stall = !stat.ready;
	assign start    = in_valid && !in_stall;
	// load the output word when the register is empty or being drained
	assign res_take = stat.res_valid && (!out_valid_q || !out_stall);

	srq_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.start    (start),
		.sample   (sample_in),
		.res_take (res_take),
		.stat     (stat),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_take)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_take)
			sample_out_q <= result;
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on consecutive cycles");

	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		stat.res_valid |-> in_stall)
		else $error("input open while a result is still held");

	a_out_from_core: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(stat.res_valid))
		else $error("output word appeared without a finished result");

endmodule
